// ===== rtl/cws_pkg.sv =====
package cws_pkg;

	// sample and table geometry
	localparam int SB        = 24;
	localparam int LUT_SIZE  = 1024;
	localparam int IDX_W     = $clog2(LUT_SIZE);
	localparam int MAX_ORDER = 7;
	localparam int NUM_COEF  = 6;
	localparam int NUM_H     = MAX_ORDER - 1;
	localparam int H_W       = 3;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int COEF_W     = 20;
	localparam int MIX_W      = 17;
	localparam logic [CFG_IDX_W-1:0] REG_MIX = 3'd6;
	localparam logic [MIX_W-1:0] MIX_ONE = 17'd65536;

	// grid step: x_i = round(2^32 * i / DEN) - 2^31, generated incrementally
	localparam longint DEN    = LUT_SIZE - 1;
	localparam longint Q_STEP = (64'sd1 <<< 32) / DEN;
	localparam longint R_STEP = (64'sd1 <<< 32) % DEN;
	localparam longint R_INIT = DEN / 2;

	// build datapath widths
	localparam int X_W = 34;
	localparam int W_W = 30;
	localparam int Y_W = 40;

	typedef enum logic [3:0] {
		B_IDLE, B_CHECK, B_WGT, B_INIT, B_MUL1, B_SUB, B_MUL2, B_ACC, B_WRITE
	} bld_state_t;

	// table write request broadcast to the lanes
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [SB-1:0]    data;
	} tbl_wr_t;

endpackage

// ===== rtl/cws_builder.sv =====
module cws_builder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cws_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           active,
	output cws_pkg::tbl_wr_t               wr
);
	import cws_pkg::*;

	bld_state_t state_q, state_d;

	logic signed [COEF_W-1:0] coef_q [NUM_COEF];
	logic [MIX_W-1:0]         mix_q;
	logic                     active_q;
	logic signed [W_W-1:0]    w_q [NUM_H];
	logic [H_W-1:0]           h_q;
	logic [IDX_W-1:0]         i_q;
	logic [32:0]              xq_q;
	logic [IDX_W-1:0]         rem_q;
	logic signed [X_W-1:0]    x_q, tm1_q, tm2_q;
	logic signed [67:0]       prod1_q;
	logic signed [63:0]       prod2_q;
	logic signed [Y_W-1:0]    y_q;

	logic                     any_coef, last_h, last_i;
	logic [MIX_W-1:0]         mix_c;
	logic signed [37:0]       wprod, wrnd;
	logic signed [67:0]       r1;
	logic signed [63:0]       r2;
	logic signed [Y_W-1:0]    r3;
	logic signed [SB-1:0]     entry;
	logic [IDX_W:0]           rem_sum;
	logic                     carry;

	// activation test and weight product
	always_comb begin
		any_coef = 1'b0;
		for (int k = 0; k < NUM_COEF; k++) begin
			if (coef_q[k] != '0) any_coef = 1'b1;
		end
		mix_c = (mix_q > MIX_ONE) ? MIX_ONE : mix_q;
		wprod = $signed({1'b0, mix_c}) * coef_q[h_q];
		wrnd  = (wprod + 38'sd128) >>> 8;
	end

	// recurrence, accumulate and entry rounding
	always_comb begin
		r1 = (prod1_q + (68'sd1 <<< 29)) >>> 30;
		r2 = (prod2_q + (64'sd1 <<< 23)) >>> 24;
		r3 = (y_q + (40'sd1 <<< 7)) >>> 8;
		if (r3 > 40'sd8388607)       entry = 24'sh7fffff;
		else if (r3 < -40'sd8388608) entry = 24'sh800000;
		else                         entry = r3[SB-1:0];
		rem_sum = {1'b0, rem_q} + (IDX_W+1)'(R_STEP);
		carry   = (rem_sum >= (IDX_W+1)'(DEN));
		last_h  = (h_q == H_W'(NUM_H - 1));
		last_i  = (i_q == IDX_W'(DEN));
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (cfg_valid && cfg_index <= REG_MIX) state_d = B_CHECK;
			end
			B_CHECK: state_d = (any_coef && mix_q != '0) ? B_WGT : B_IDLE;
			B_WGT:   state_d = last_h ? B_INIT : B_WGT;
			B_INIT:  state_d = B_MUL1;
			B_MUL1:  state_d = B_SUB;
			B_SUB:   state_d = B_MUL2;
			B_MUL2:  state_d = B_ACC;
			B_ACC:   state_d = last_h ? B_WRITE : B_MUL1;
			B_WRITE: state_d = last_i ? B_IDLE : B_INIT;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else         state_q <= state_d;
	end

	// configuration registers and activity flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_COEF; k++) coef_q[k] <= '0;
			mix_q    <= '0;
			active_q <= 1'b0;
		end else begin
			if (state_q == B_IDLE && cfg_valid) begin
				if (cfg_index < REG_MIX) coef_q[cfg_index] <= $signed(cfg_data[COEF_W-1:0]);
				else if (cfg_index == REG_MIX) mix_q <= cfg_data[MIX_W-1:0];
			end
			if (state_q == B_CHECK) active_q <= 1'b0;
			if (state_q == B_WRITE && last_i) active_q <= 1'b1;
		end
	end

	// build datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_CHECK: begin
				h_q   <= '0;
				i_q   <= '0;
				xq_q  <= '0;
				rem_q <= IDX_W'(R_INIT);
			end
			B_WGT: begin
				w_q[h_q] <= wrnd[W_W-1:0];
				h_q      <= last_h ? '0 : h_q + 1'b1;
			end
			B_INIT: begin
				x_q   <= $signed({1'b0, xq_q}) - (34'sd1 <<< 31);
				tm1_q <= $signed({1'b0, xq_q}) - (34'sd1 <<< 31);
				tm2_q <= 34'sd1 <<< 31;
				y_q   <= Y_W'($signed({1'b0, xq_q}) - (34'sd1 <<< 31));
				h_q   <= '0;
			end
			B_MUL1: prod1_q <= x_q * tm1_q;
			B_SUB: begin
				tm1_q <= $signed(r1[X_W-1:0]) - tm2_q;
				tm2_q <= tm1_q;
			end
			B_MUL2: prod2_q <= w_q[h_q] * tm1_q;
			B_ACC: begin
				y_q <= y_q + $signed(r2[Y_W-1:0]);
				h_q <= h_q + 1'b1;
			end
			B_WRITE: begin
				i_q   <= i_q + 1'b1;
				xq_q  <= xq_q + 33'(Q_STEP) + {32'd0, carry};
				rem_q <= carry ? rem_sum[IDX_W-1:0] - IDX_W'(DEN) : rem_sum[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	assign cfg_ready = (state_q == B_IDLE);
	assign active    = active_q;
	assign wr.en     = (state_q == B_WRITE);
	assign wr.addr   = i_q;
	assign wr.data   = entry;
endmodule

// ===== rtl/cws_lane.sv =====
module cws_lane (
	input  logic                        clk,
	input  logic                        en,
	input  cws_pkg::tbl_wr_t            wr,
	input  logic signed [cws_pkg::SB-1:0] sample,
	output logic signed [cws_pkg::SB+18:0] sum_s2,
	output logic signed [cws_pkg::SB-1:0]  samp_s2
);
	import cws_pkg::*;

	logic signed [SB-1:0] mem [LUT_SIZE];

	logic [SB-1:0]       u;
	logic [SB+IDX_W-1:0] p;
	logic [SB+15:0]      fw;
	logic [IDX_W-1:0]    i0, i1;
	logic [15:0]         frac;

	logic signed [SB-1:0] a_s1, b_s1, samp_s1;
	logic [15:0]          frac_s1;
	logic [16:0]          wa;

	// table position and fraction of the sample
	always_comb begin
		u    = {~sample[SB-1], sample[SB-2:0]};
		p    = (SB+IDX_W)'(u) * (SB+IDX_W)'(DEN);
		i0   = p[SB+IDX_W-1:SB];
		i1   = (i0 == IDX_W'(DEN)) ? i0 : i0 + 1'b1;
		fw   = {p[SB-1:0], 16'd0} >> SB;
		frac = fw[15:0];
		wa   = 17'd65536 - {1'b0, frac_s1};
	end

	// table store, two read ports
	always_ff @(posedge clk) begin
		if (wr.en) mem[wr.addr] <= $signed(wr.data);
		if (en) begin
			a_s1    <= mem[i0];
			b_s1    <= mem[i1];
			frac_s1 <= frac;
			samp_s1 <= sample;
		end
	end

	// interpolation products
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= (SB+19)'(a_s1 * $signed({1'b0, wa}))
			         + (SB+19)'(b_s1 * $signed({2'b0, frac_s1}));
			samp_s2 <= samp_s1;
		end
	end
endmodule

// ===== rtl/chebyshev_waveshaper_stereo.sv =====
// Stereo Chebyshev waveshaper with an interpolated transfer table.
// Input stream s_*: tdata = left_sample [23:0], right_sample [47:24];
// tlast = end_of_block. Output stream m_*: left_shaped, right_shaped in
// the same places, tlast = end_of_block_out.
// Config channel cfg_*: index 0..5 = coef_h2..coef_h7, 6 = mix_amount;
// higher indexes are taken and ignored.
// A write that leaves the shaper active rebuilds the 1024-entry table with
// one shared multiply sequencer, during which cfg_ready and s_tready are
// low. Otherwise only the activation check holds them low.
// Each lane holds its own copy of the table with two read ports, so one
// frame is accepted every cycle unless the output stalls or cfg_ready is
// low; three register stages (s1, s2, output) lead to m_tvalid.
// A stall on m_tready freezes the whole pipeline and drops s_tready.
// Reset clears the control and configuration registers; the shaper then
// passes samples through unchanged until a configuration write activates it.
module chebyshev_waveshaper_stereo (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // left_sample, right_sample
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // left_shaped, right_shaped
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [cws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cws_pkg::CFG_DATA_W-1:0] cfg_data
);
	import cws_pkg::*;

	tbl_wr_t wr;
	logic    active, en, v_s1, v_s2, last_s1, last_s2;
	logic signed [SB+18:0] sum_l, sum_r;
	logic signed [SB-1:0]  samp_l, samp_r, out_l, out_r;

	cws_builder u_bld (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.active, .wr
	);

	cws_lane u_lane_l (
		.clk, .en, .wr, .sample($signed(s_tdata[23:0])),
		.sum_s2(sum_l), .samp_s2(samp_l)
	);

	cws_lane u_lane_r (
		.clk, .en, .wr, .sample($signed(s_tdata[47:24])),
		.sum_s2(sum_r), .samp_s2(samp_r)
	);

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en && cfg_ready;

	function automatic logic signed [SB-1:0] rnd_sat(input logic signed [SB+18:0] s);
		logic signed [SB+18:0] r;
		r = (s + (43'sd1 <<< 15)) >>> 16;
		if (r > 43'sd8388607)       return 24'sh7fffff;
		else if (r < -43'sd8388608) return 24'sh800000;
		else                        return r[SB-1:0];
	endfunction

	// merge: round the lane sums or pass through
	always_comb begin
		out_l = active ? rnd_sat(sum_l) : samp_l;
		out_r = active ? rnd_sat(sum_r) : samp_r;
	end

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= s_tvalid && cfg_ready;
			v_s2     <= v_s1;
			m_tvalid <= v_s2;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			last_s1 <= s_tlast;
			last_s2 <= last_s1;
			m_tlast <= last_s2;
			m_tdata <= {out_r, out_l};
		end
	end
endmodule

// ===== rtl/cws_checker.sv =====
module cws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tlast,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index
);
	import cws_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// no frames taken while the table is being rebuilt
	a_build_block: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> !s_tready)
		else $error("frame accepted during rebuild");

	// a valid register write always goes through the activation check
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index <= REG_MIX |=> !cfg_ready && !s_tready)
		else $error("register write not followed by check");
endmodule

bind chebyshev_waveshaper_stereo cws_checker u_chk (
	.clk, .arst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast,
	.cfg_valid, .cfg_ready, .cfg_index
);
